FILE: rtl/core/rsch_pkg.sv
// rsch_pkg: widths, codes, state encoding and control structs for the
// ray/sphere closest-hit unit; no dependencies, imported by every rtl/core module
`default_nettype none

package rsch_pkg;

  // field widths
  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;
  localparam int DIST_W  = 31;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int ENTRY_W = 3 * POS_W + RAD_W;

  // wide arithmetic: 68-bit signed operands, 136-bit accumulator
  localparam int OPW      = 68;
  localparam int CHW      = 17;
  localparam int NCH      = OPW / CHW;
  localparam int ACCW     = 2 * OPW;
  localparam int A_W      = 64;
  localparam int NW       = OPW + 2;
  localparam int SQ_IT    = ACCW / 2;
  localparam int SQ_REM_W = OPW + 2;
  localparam int IT_W     = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_MUL,
    ST_RD,
    ST_RD_WAIT,
    ST_H_MUL,
    ST_C_MUL,
    ST_D_MUL,
    ST_SQRT,
    ST_ROOT,
    ST_DIV,
    ST_CHECK,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic negate;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsch_mac.sv
// rsch_mac: multi-cycle signed 68x68 multiply-accumulate, one 68x17 partial
// product per cycle into a 136-bit accumulator; depends on rsch_pkg
`default_nettype none

module rsch_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsch_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [rsch_pkg::OPW-1:0]     x_i,
  input  logic signed [rsch_pkg::OPW-1:0]     y_i,
  output rsch_pkg::mac_stat_t                 stat_o,
  output logic signed [rsch_pkg::ACCW-1:0]    acc_o
);
  import rsch_pkg::*;

  logic [OPW-1:0]         abs_x, abs_y;
  logic [OPW-1:0]         ma_q, mb_q;
  logic                   sign_q, clear_q;
  logic                   busy_q, done_q;
  logic [2:0]             cnt_q;
  logic [ACCW-1:0]        prod_q, pp_sh;
  logic [OPW+CHW-1:0]     pp;
  logic signed [ACCW-1:0] acc_q, base;

  // magnitudes, sign handled at the end
  assign abs_x = x_i[OPW-1] ? OPW'(-x_i) : OPW'(x_i);
  assign abs_y = y_i[OPW-1] ? OPW'(-y_i) : OPW'(y_i);

  // one chunk of the multiplier per cycle
  assign pp    = (OPW+CHW)'(ma_q) * (OPW+CHW)'(mb_q[CHW-1:0]);
  assign pp_sh = ACCW'(pp) << (CHW * cnt_q);
  assign base  = clear_q ? '0 : acc_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q && cnt_q < 3'(NCH)) begin
        cnt_q <= cnt_q + 3'd1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ma_q    <= abs_x;
      mb_q    <= abs_y;
      sign_q  <= x_i[OPW-1] ^ y_i[OPW-1] ^ ctrl_i.negate;
      clear_q <= ctrl_i.clear;
      prod_q  <= '0;
    end else if (busy_q && cnt_q < 3'(NCH)) begin
      prod_q <= prod_q + pp_sh;
      mb_q   <= mb_q >> CHW;
    end else if (busy_q) begin
      acc_q <= sign_q ? base - $signed(prod_q) : base + $signed(prod_q);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;

endmodule

`default_nettype wire

FILE: rtl/core/ray_sphere_closest_hit_unit.sv
// ray_sphere_closest_hit_unit: sphere table in a synchronous memory and a
// sequencer for the closest-hit search; depends on rsch_pkg and rsch_mac
`default_nettype none

// A load request (func 0) writes one sphere entry and gives
// no result. A query request (func 1) searches entries 0 .. sphere_count-1
// (capped at MAX_SPHERES) and always gives exactly one result, shown for one
// cycle with result_valid_o; the receiver cannot stall it, so it must take it
// then. busy stays high from query acceptance until the cycle before the
// result. Each multiplication uses the shared 68x17 multiply-accumulate,
// the square root resolves one result bit per cycle, and each tried root
// (near, then far) divides one quotient bit per cycle. Entries must be
// loaded before a query searches them; there is no clearing pass.
module ray_sphere_closest_hit_unit #(
  parameter int MAX_SPHERES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func_i,
  input  logic [rsch_pkg::IDX_W-1:0]           sphere_index_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    pos_z_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    dir_x_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    dir_y_i,
  input  logic signed [rsch_pkg::POS_W-1:0]    dir_z_i,
  input  logic [rsch_pkg::RAD_W-1:0]           radius_i,
  input  logic                                 cfg_we_i,
  input  logic [rsch_pkg::CNT_W-1:0]           cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic                                 hit_o,
  output logic [rsch_pkg::IDX_W-1:0]           hit_index_o,
  output logic [rsch_pkg::DIST_W-1:0]          hit_distance_o
);
  import rsch_pkg::*;

  localparam int AW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW  = $clog2(MAX_SPHERES + 1);
  localparam int SHR = 31 - FRAC_BITS;
  localparam logic [DIST_W-1:0] TMIN = DIST_W'((2 ** FRAC_BITS + 500) / 1000);

  state_e state_q, state_d;

  logic [CNT_W-1:0]          count_q;
  logic [CW-1:0]             limit, idx_q, idx_inc;
  logic                      accept;

  // sphere table
  logic [ENTRY_W-1:0]        sph_mem [MAX_SPHERES];
  logic [ENTRY_W-1:0]        rd_data_q;
  logic                      wr_en;
  logic signed [POS_W-1:0]   mem_cx, mem_cy, mem_cz;

  // query and per-sphere working registers
  logic signed [POS_W-1:0]   ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
  logic [A_W-1:0]            a_q;
  logic signed [POS_W:0]     cx_q, cy_q, cz_q;
  logic [RAD_W-1:0]          r_q;
  logic signed [OPW-1:0]     h_q, c_q;
  logic [ACCW-1:0]           rad_q;
  logic [SQ_REM_W-1:0]       sq_rem_q;
  logic [OPW-1:0]            root_q;
  logic [IT_W-1:0]           it_q;
  logic [1:0]                k_q;
  logic                      far_q;
  logic [DIST_W-1:0]         n_low_q;
  logic [A_W-1:0]            div_rem_q;
  logic [DIST_W-1:0]         t_q;
  logic                      t_ok_q;
  logic [DIST_W:0]           closest_q;
  logic [AW-1:0]             best_q;
  logic                      found_q;
  logic                      valid_q, hit_q;
  logic [IDX_W-1:0]          hit_index_q;
  logic [DIST_W-1:0]         hit_dist_q;

  // multiply-accumulate hookup
  mac_ctrl_t                 mac_ctrl;
  mac_stat_t                 mac_stat;
  logic signed [OPW-1:0]     mx, my;
  logic signed [ACCW-1:0]    acc;
  logic                      mul_state, mul_last;

  // step logic
  logic [SQ_REM_W+1:0]       sq_rem2, sq_trial;
  logic                      sq_ge;
  logic signed [NW-1:0]      n_val;
  logic [NW-1:0]             n_hi, n_sh;
  logic                      n_neg, root_sat;
  logic [A_W:0]              div_r2;
  logic                      div_ge;
  logic                      hit_ok;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = idx_q + CW'(1);

  // search length capped at table depth
  assign limit = ({25'b0, count_q} > 32'(MAX_SPHERES)) ? CW'(MAX_SPHERES) : CW'(count_q);

  assign wr_en = accept && (func_i == FUNC_LOAD) &&
                 ({26'b0, sphere_index_i} < 32'(MAX_SPHERES));

  // table write and registered read, never overlapping since busy blocks loads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sph_mem[AW'(sphere_index_i)] <= {radius_i, pos_z_i, pos_y_i, pos_x_i};
    end
    rd_data_q <= sph_mem[idx_q[AW-1:0]];
  end

  assign mem_cx = rd_data_q[POS_W-1:0];
  assign mem_cy = rd_data_q[2*POS_W-1:POS_W];
  assign mem_cz = rd_data_q[3*POS_W-1:2*POS_W];

  // operand selection for the shared multiplier
  always_comb begin
    mx       = '0;
    my       = '0;
    mul_last = 1'b0;
    mul_state = 1'b1;
    mac_ctrl.clear  = (k_q == 2'd0);
    mac_ctrl.negate = 1'b0;
    case (state_q)
      ST_A_MUL: begin
        mul_last = (k_q == 2'd2);
        case (k_q)
          2'd0:    begin mx = OPW'(dx_q); my = OPW'(dx_q); end
          2'd1:    begin mx = OPW'(dy_q); my = OPW'(dy_q); end
          default: begin mx = OPW'(dz_q); my = OPW'(dz_q); end
        endcase
      end
      ST_H_MUL: begin
        mul_last = (k_q == 2'd2);
        case (k_q)
          2'd0:    begin mx = OPW'(cx_q); my = OPW'(dx_q); end
          2'd1:    begin mx = OPW'(cy_q); my = OPW'(dy_q); end
          default: begin mx = OPW'(cz_q); my = OPW'(dz_q); end
        endcase
      end
      ST_C_MUL: begin
        mul_last = (k_q == 2'd3);
        case (k_q)
          2'd0:    begin mx = OPW'(cx_q); my = OPW'(cx_q); end
          2'd1:    begin mx = OPW'(cy_q); my = OPW'(cy_q); end
          2'd2:    begin mx = OPW'(cz_q); my = OPW'(cz_q); end
          default: begin
            mx = $signed(OPW'(r_q));
            my = $signed(OPW'(r_q));
            mac_ctrl.negate = 1'b1;
          end
        endcase
      end
      ST_D_MUL: begin
        mul_last = (k_q == 2'd1);
        if (k_q == 2'd0) begin
          mx = h_q;
          my = h_q;
        end else begin
          mx = $signed(OPW'(a_q));
          my = c_q;
          mac_ctrl.negate = 1'b1;
        end
      end
      default: mul_state = 1'b0;
    endcase
    mac_ctrl.start = mul_state && !mac_stat.busy && !mac_stat.done;
  end

  rsch_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (mx),
    .y_i    (my),
    .stat_o (mac_stat),
    .acc_o  (acc)
  );

  // square root step, two radicand bits per cycle
  assign sq_rem2  = {sq_rem_q, rad_q[ACCW-1:ACCW-2]};
  assign sq_trial = (SQ_REM_W+2)'({root_q, 2'b01});
  assign sq_ge    = (sq_rem2 >= sq_trial);

  // root numerator, saturation check and division setup
  assign n_val    = far_q ? -NW'(h_q) + $signed(NW'(root_q))
                          : -NW'(h_q) - $signed(NW'(root_q));
  assign n_neg    = n_val[NW-1];
  assign n_hi     = $unsigned(n_val) >> SHR;
  assign n_sh     = $unsigned(n_val) << FRAC_BITS;
  assign root_sat = !n_neg && (n_hi >= NW'(a_q));

  // restoring divide step
  assign div_r2 = {div_rem_q, n_low_q[DIST_W-1]};
  assign div_ge = (div_r2 >= {1'b0, a_q});

  // range test against the running closest
  assign hit_ok = t_ok_q && (t_q > TMIN) && ({1'b0, t_q} < closest_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && func_i == FUNC_QUERY) state_d = ST_A_MUL;
      end
      ST_A_MUL: begin
        if (mac_stat.done && mul_last) begin
          state_d = (acc[A_W-1:0] == '0 || limit == '0) ? ST_DONE : ST_RD;
        end
      end
      ST_RD:      state_d = ST_RD_WAIT;
      ST_RD_WAIT: state_d = ST_H_MUL;
      ST_H_MUL: begin
        if (mac_stat.done && mul_last) state_d = ST_C_MUL;
      end
      ST_C_MUL: begin
        if (mac_stat.done && mul_last) state_d = ST_D_MUL;
      end
      ST_D_MUL: begin
        if (mac_stat.done && mul_last) state_d = acc[ACCW-1] ? ST_NEXT : ST_SQRT;
      end
      ST_SQRT: begin
        if (it_q == IT_W'(SQ_IT - 1)) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        state_d = (n_neg || root_sat) ? ST_CHECK : ST_DIV;
      end
      ST_DIV: begin
        if (it_q == IT_W'(DIST_W - 1)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit_ok)      state_d = ST_NEXT;
        else if (!far_q) state_d = ST_ROOT;
        else             state_d = ST_NEXT;
      end
      ST_NEXT: state_d = (idx_inc == limit) ? ST_DONE : ST_RD;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
      k_q     <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == ST_DONE);
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (mul_state && mac_stat.done) k_q <= mul_last ? 2'd0 : k_q + 2'd1;
      if (state_q == ST_SQRT || state_q == ST_DIV) begin
        it_q <= (state_d != state_q) ? '0 : it_q + IT_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept && func_i == FUNC_QUERY) begin
      ox_q      <= pos_x_i;
      oy_q      <= pos_y_i;
      oz_q      <= pos_z_i;
      dx_q      <= dir_x_i;
      dy_q      <= dir_y_i;
      dz_q      <= dir_z_i;
      closest_q <= {1'b1, DIST_W'(0)};
      best_q    <= '0;
      found_q   <= 1'b0;
      idx_q     <= '0;
    end
    case (state_q)
      ST_A_MUL: begin
        if (mac_stat.done && mul_last) a_q <= acc[A_W-1:0];
      end
      ST_RD_WAIT: begin
        cx_q <= $signed({ox_q[POS_W-1], ox_q}) - $signed({mem_cx[POS_W-1], mem_cx});
        cy_q <= $signed({oy_q[POS_W-1], oy_q}) - $signed({mem_cy[POS_W-1], mem_cy});
        cz_q <= $signed({oz_q[POS_W-1], oz_q}) - $signed({mem_cz[POS_W-1], mem_cz});
        r_q  <= rd_data_q[ENTRY_W-1:3*POS_W];
      end
      ST_H_MUL: begin
        if (mac_stat.done && mul_last) h_q <= acc[OPW-1:0];
      end
      ST_C_MUL: begin
        if (mac_stat.done && mul_last) c_q <= acc[OPW-1:0];
      end
      ST_D_MUL: begin
        if (mac_stat.done && mul_last) begin
          rad_q    <= acc;
          sq_rem_q <= '0;
          root_q   <= '0;
          far_q    <= 1'b0;
        end
      end
      ST_SQRT: begin
        rad_q    <= rad_q << 2;
        sq_rem_q <= sq_ge ? SQ_REM_W'(sq_rem2 - sq_trial) : SQ_REM_W'(sq_rem2);
        root_q   <= {root_q[OPW-2:0], sq_ge};
      end
      ST_ROOT: begin
        div_rem_q <= n_hi[A_W-1:0];
        n_low_q   <= n_sh[DIST_W-1:0];
        t_ok_q    <= !n_neg;
        if (root_sat) t_q <= DIST_MAX;
      end
      ST_DIV: begin
        div_rem_q <= div_ge ? A_W'(div_r2 - {1'b0, a_q}) : div_r2[A_W-1:0];
        n_low_q   <= n_low_q << 1;
        t_q       <= {t_q[DIST_W-2:0], div_ge};
      end
      ST_CHECK: begin
        if (hit_ok) begin
          closest_q <= {1'b0, t_q};
          best_q    <= idx_q[AW-1:0];
          found_q   <= 1'b1;
        end else if (!far_q) begin
          far_q <= 1'b1;
        end
      end
      ST_NEXT: idx_q <= idx_inc;
      ST_DONE: begin
        hit_q       <= found_q;
        hit_index_q <= found_q ? IDX_W'(best_q) : '0;
        hit_dist_q  <= found_q ? closest_q[DIST_W-1:0] : '0;
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign hit_o          = hit_q;
  assign hit_index_o    = hit_index_q;
  assign hit_distance_o = hit_dist_q;

  // checks
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while a query is in flight");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |-> hit_distance_o == '0 && hit_index_o == '0)
    else $error("miss result carries nonzero fields");

  a_hit_above_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && hit_o |-> hit_distance_o > TMIN)
    else $error("hit distance not above minimum");

  a_mac_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.start |-> !mac_stat.busy && mul_state)
    else $error("multiplier started while busy");

endmodule

`default_nettype wire
